// ----- hdl/brf_pkg.sv -----
`default_nettype none
package brf_pkg;

  // Store geometry
  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned POS_W     = ADDR_W + 1;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);

  // Field widths
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned WIDE_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = ((DATA_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = MODE_W;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + 3 * CNT_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 1;

  // Queues
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 3'd0,
    MODE_READ   = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_SKIP   = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_STATUS = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_PEEK,
    K_SKIP,
    K_CLEAR,
    K_STATUS
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              byte_valid;
    logic [CNT_W-1:0]  done_count;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  space_left;
    logic              last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } oq_push_t;

endpackage
`default_nettype wire

// ----- hdl/byte_ring_fifo_peek_skip.sv -----
`default_nettype none
// Byte FIFO driven by a command stream. Each slave-side item is one command
// (write byte, read, peek, skip, clear, status); each master-side item is one
// result. Write, skip, clear and status give one result; read and peek give
// one result per delivered byte (at most 64, bounded by the fill level), or a
// single empty result when nothing can be delivered. tlast marks the final
// result of a command.
// The result of a write, skip, clear or status command passes through the
// command queue, the execute stage and the result queue before it is offered;
// the first byte of a read or peek also passes through the burst state, where
// the registered store read runs alongside the staged result.
// While the result queue has room, write, skip, clear and status run at one
// command per cycle and the single read port of the byte store delivers one
// byte per cycle; no later command runs until a read or peek is through.
// Reset clears both positions and empties both queues; the store contents
// stay undefined and need no clearing pass, since only written bytes are read.
// When the receiver stalls, the four-entry result queue fills, execution
// pauses, the two-entry command queue fills and s_axis_tready drops.
module byte_ring_fifo_peek_skip (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] data_in, [20:8] count, [23:21] zero
  input  wire logic [brf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [2:0] mode
  input  wire logic [brf_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] data_out, [20:8] done_count, [33:21] fill_level,
  // [46:34] space_left, [47] zero
  output logic [brf_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [0] byte_valid
  output logic [brf_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
  output logic                                   m_axis_tlast
);

  logic                            cmd_valid;
  brf_pkg::cmd_t                   cmd;
  logic                            cmd_pop;
  logic [brf_pkg::OQ_CNT_W-1:0]    oq_cnt;
  brf_pkg::oq_push_t               oq_push;

  brf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  brf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .oq_cnt_i    (oq_cnt),
    .push_o      (oq_push)
  );

  brf_out_queue u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (oq_push),
    .cnt_o      (oq_cnt),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- hdl/brf_front.sv -----
`default_nettype none
module brf_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [brf_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  wire logic [brf_pkg::IN_TUSER_W-1:0]    s_tuser_i,
  output logic                                   cmd_valid_o,
  output brf_pkg::cmd_t                          cmd_o,
  input  wire logic                              cmd_pop_i
);

  localparam int unsigned DataW = brf_pkg::DATA_W;
  localparam int unsigned CntW  = brf_pkg::CNT_W;
  localparam int unsigned PtrW  = brf_pkg::CQ_PTR_W;
  localparam int unsigned QCntW = brf_pkg::CQ_CNT_W;

  brf_pkg::cmd_t    cmd_in;
  logic [CntW-1:0]  raw_cnt;
  logic [CntW-1:0]  burst_cnt;

  brf_pkg::cmd_t    cq_q [brf_pkg::CQ_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;

  // Classify the incoming item and clamp burst counts
  assign raw_cnt   = s_tdata_i[DataW +: CntW];
  assign burst_cnt = (raw_cnt > CntW'(brf_pkg::MAX_BURST)) ? CntW'(brf_pkg::MAX_BURST) : raw_cnt;

  always_comb begin
    cmd_in       = '0;
    cmd_in.data  = s_tdata_i[DataW-1:0];
    cmd_in.count = raw_cnt;
    unique case (brf_pkg::mode_e'(s_tuser_i))
      brf_pkg::MODE_WRITE: cmd_in.kind = brf_pkg::K_WRITE;
      brf_pkg::MODE_READ: begin
        cmd_in.kind  = brf_pkg::K_READ;
        cmd_in.count = burst_cnt;
      end
      brf_pkg::MODE_PEEK: begin
        cmd_in.kind  = brf_pkg::K_PEEK;
        cmd_in.count = burst_cnt;
      end
      brf_pkg::MODE_SKIP:  cmd_in.kind = brf_pkg::K_SKIP;
      brf_pkg::MODE_CLEAR: cmd_in.kind = brf_pkg::K_CLEAR;
      default:             cmd_in.kind = brf_pkg::K_STATUS;
    endcase
  end

  // Command queue toward the back end
  assign s_tready_o  = (cnt_q != QCntW'(brf_pkg::CQ_DEPTH));
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cq_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push) - QCntW'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cq_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/brf_back.sv -----
`default_nettype none
module brf_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire brf_pkg::cmd_t                 cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic [brf_pkg::OQ_CNT_W-1:0]  oq_cnt_i,
  output brf_pkg::oq_push_t                  push_o
);

  localparam int unsigned AddrW  = brf_pkg::ADDR_W;
  localparam int unsigned PosW   = brf_pkg::POS_W;
  localparam int unsigned CntW   = brf_pkg::CNT_W;
  localparam int unsigned BurstW = brf_pkg::BURST_W;
  localparam int unsigned WideW  = brf_pkg::WIDE_W;
  localparam int unsigned DataW  = brf_pkg::DATA_W;
  localparam int unsigned OccW   = brf_pkg::OQ_CNT_W + 1;

  brf_pkg::state_e   state_q, state_d;
  logic [PosW-1:0]   rp_q, rp_d;
  logic [PosW-1:0]   wp_q, wp_d;
  logic [PosW-1:0]   bp_q, bp_d;
  logic [BurstW-1:0] rem_q, rem_d;
  logic [CntW-1:0]   bdone_q, bdone_d;
  logic [PosW-1:0]   bfill_q, bfill_d;
  logic              pend_vld_q, pend_vld_d;
  brf_pkg::res_t     pend_q, pend_d;
  logic [DataW-1:0]  rdata_q;
  logic [DataW-1:0]  mem [brf_pkg::DEPTH];

  logic [PosW-1:0]   fill_cur;
  logic              full;
  logic [OccW-1:0]   occ;
  logic              room;
  logic [WideW-1:0]  wide_cnt;
  logic [WideW-1:0]  wide_fill;
  logic [WideW-1:0]  n_w;
  logic [PosW-1:0]   n_pos;
  logic [PosW-1:0]   fill_after;
  logic              is_burst;
  logic              mem_we;
  logic              rd_en;

  function automatic brf_pkg::res_t status_res(input logic [PosW-1:0] fill);
    brf_pkg::res_t r;
    r            = '0;
    r.fill_level = CntW'(fill);
    r.space_left = CntW'(PosW'(brf_pkg::DEPTH) - fill);
    r.last       = 1'b1;
    return r;
  endfunction

  // Fill level, result queue room and the clamped command count
  assign fill_cur   = wp_q - rp_q;
  assign full       = (fill_cur == PosW'(brf_pkg::DEPTH));
  assign occ        = OccW'(oq_cnt_i) + OccW'(pend_vld_q);
  assign room       = (occ < OccW'(brf_pkg::OQ_DEPTH));
  assign wide_cnt   = WideW'(cmd_i.count);
  assign wide_fill  = WideW'(fill_cur);
  assign n_w        = (wide_cnt < wide_fill) ? wide_cnt : wide_fill;
  assign n_pos      = PosW'(n_w);
  assign fill_after = fill_cur - n_pos;
  assign is_burst   = (cmd_i.kind == brf_pkg::K_READ) || (cmd_i.kind == brf_pkg::K_PEEK);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brf_pkg::ST_IDLE: begin
        if (cmd_valid_i && room && is_burst && (n_w != '0)) begin
          state_d = brf_pkg::ST_BURST;
        end
      end
      brf_pkg::ST_BURST: begin
        if (room && (rem_q == BurstW'(1))) begin
          state_d = brf_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Execute commands and stage results
  always_comb begin
    cmd_pop_o  = 1'b0;
    rp_d       = rp_q;
    wp_d       = wp_q;
    bp_d       = bp_q;
    rem_d      = rem_q;
    bdone_d    = bdone_q;
    bfill_d    = bfill_q;
    pend_vld_d = 1'b0;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    unique case (state_q)
      brf_pkg::ST_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_pop_o  = 1'b1;
          pend_vld_d = 1'b1;
          pend_d     = status_res(fill_cur);
          unique case (cmd_i.kind)
            brf_pkg::K_WRITE: begin
              if (!full) begin
                mem_we            = 1'b1;
                wp_d              = wp_q + PosW'(1);
                pend_d            = status_res(fill_cur + PosW'(1));
                pend_d.done_count = CntW'(1);
              end
            end
            brf_pkg::K_READ, brf_pkg::K_PEEK: begin
              if (n_w != '0) begin
                pend_vld_d = 1'b0;
                bp_d       = rp_q;
                rem_d      = BurstW'(n_w);
                bdone_d    = CntW'(n_w);
                if (cmd_i.kind == brf_pkg::K_READ) begin
                  rp_d    = rp_q + n_pos;
                  bfill_d = fill_after;
                end else begin
                  bfill_d = fill_cur;
                end
              end
            end
            brf_pkg::K_SKIP: begin
              rp_d              = rp_q + n_pos;
              pend_d            = status_res(fill_after);
              pend_d.done_count = CntW'(n_w);
            end
            brf_pkg::K_CLEAR: begin
              rp_d   = '0;
              wp_d   = '0;
              pend_d = status_res('0);
            end
            brf_pkg::K_STATUS: begin
              pend_d = status_res(fill_cur);
            end
            default: begin
              pend_d = status_res(fill_cur);
            end
          endcase
        end
      end
      brf_pkg::ST_BURST: begin
        if (room) begin
          rd_en             = 1'b1;
          bp_d              = bp_q + PosW'(1);
          rem_d             = rem_q - BurstW'(1);
          pend_vld_d        = 1'b1;
          pend_d            = status_res(bfill_q);
          pend_d.byte_valid = 1'b1;
          pend_d.done_count = bdone_q;
          pend_d.last       = (rem_q == BurstW'(1));
        end
      end
    endcase
  end

  // Merge the store read data into a byte result
  always_comb begin
    push_o.valid = pend_vld_q;
    push_o.res   = pend_q;
    if (pend_q.byte_valid) begin
      push_o.res.data_out = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= brf_pkg::ST_IDLE;
      rp_q       <= '0;
      wp_q       <= '0;
      rem_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      rem_q      <= rem_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q    <= bp_d;
    bdone_q <= bdone_d;
    bfill_q <= bfill_d;
    pend_q  <= pend_d;
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q[AddrW-1:0]] <= cmd_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[bp_q[AddrW-1:0]];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cur <= PosW'(brf_pkg::DEPTH))
    else $error("fill level exceeds store depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (oq_cnt_i < brf_pkg::OQ_CNT_W'(brf_pkg::OQ_DEPTH)))
    else $error("result pushed into a full result queue");

  a_burst_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brf_pkg::ST_BURST) |-> (rem_q != '0))
    else $error("burst running with no bytes left");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command popped from an empty queue");

  a_burst_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_vld_q && pend_q.byte_valid) |-> $past(state_q == brf_pkg::ST_BURST))
    else $error("byte result staged outside a burst");

endmodule
`default_nettype wire

// ----- hdl/brf_out_queue.sv -----
`default_nettype none
module brf_out_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire brf_pkg::oq_push_t                 push_i,
  output logic [brf_pkg::OQ_CNT_W-1:0]           cnt_o,
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [brf_pkg::OUT_TDATA_W-1:0]        m_tdata_o,
  output logic [brf_pkg::OUT_TUSER_W-1:0]        m_tuser_o,
  output logic                                   m_tlast_o
);

  localparam int unsigned PtrW   = brf_pkg::OQ_PTR_W;
  localparam int unsigned QCntW  = brf_pkg::OQ_CNT_W;
  localparam int unsigned TdataW = brf_pkg::OUT_TDATA_W;
  localparam int unsigned TuserW = brf_pkg::OUT_TUSER_W;

  brf_pkg::res_t    oq_q [brf_pkg::OQ_DEPTH];
  brf_pkg::res_t    head;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  // Present the head item
  assign head       = oq_q[rd_ptr_q];
  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = TdataW'({head.space_left, head.fill_level, head.done_count, head.data_out});
  assign m_tuser_o  = TuserW'(head.byte_valid);
  assign m_tlast_o  = head.last;
  assign cnt_o      = cnt_q;
  assign pop        = m_tvalid_o && m_tready_i;

  // Advance pointers
  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i.valid) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      oq_q[wr_ptr_q] <= push_i.res;
    end
  end

endmodule
`default_nettype wire
